[rtl/core/i2c_master_byte_engine_unit_assert.svh]
// Assertion macros for the I2C master byte engine RTL.
// Included by the modules that carry concurrent checks; needs clock and reset in scope.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// check that is switched off while reset is high
`define I2CMBE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// check that also holds across reset
`define I2CMBE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`else

`define I2CMBE_ASSERT(lbl, prop, msg)

`define I2CMBE_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/core/i2cmbe_pkg.sv]
// Shared types, codes and helpers for the I2C master byte engine.
// No dependencies; imported by i2cmbe_step and i2c_master_byte_engine_unit.
package i2cmbe_pkg;

   localparam int DELAY_BITS   = 16;
   localparam int TIMEOUT_BITS = 20;

   // command codes on req_func
   localparam logic [2:0] FUNC_NONE    = 3'd0;
   localparam logic [2:0] FUNC_START   = 3'd1;
   localparam logic [2:0] FUNC_RESTART = 3'd2;
   localparam logic [2:0] FUNC_STOP    = 3'd3;
   localparam logic [2:0] FUNC_WRITE   = 3'd4;
   localparam logic [2:0] FUNC_READ    = 3'd5;

   // register indexes (word address)
   localparam logic [1:0] REG_DELAY   = 2'd0;
   localparam logic [1:0] REG_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_SENSE   = 2'd2;

   // command status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NAK     = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

   localparam logic [7:0] BYTE_MSB   = 8'h80;
   localparam logic [3:0] BITS_BYTE  = 4'd8;

   // sequencer phases
   typedef enum logic [19:0] {
      PH_IDLE      = 20'h00001,
      PH_START_SDA = 20'h00002,
      PH_START_SCL = 20'h00004,
      PH_RS_SDA    = 20'h00008,
      PH_RS_SCLHI  = 20'h00010,
      PH_SP_SDA    = 20'h00020,
      PH_SP_SCLHI  = 20'h00040,
      PH_SP_REL    = 20'h00080,
      PH_WR_BIT    = 20'h00100,
      PH_WR_SCLHI  = 20'h00200,
      PH_WR_SCLLO  = 20'h00400,
      PH_WR_REL    = 20'h00800,
      PH_WR_ACKHI  = 20'h01000,
      PH_WR_ACKLO  = 20'h02000,
      PH_RD_REL    = 20'h04000,
      PH_RD_SCLHI  = 20'h08000,
      PH_RD_SAMPLE = 20'h10000,
      PH_AK_SDA    = 20'h20000,
      PH_AK_SCLHI  = 20'h40000,
      PH_AK_SCLLO  = 20'h80000
   } phase_type;

   typedef struct packed {
      logic [DELAY_BITS-1:0]   delay;
      logic [TIMEOUT_BITS-1:0] timeout;
      logic                    sense;
   } cfg_type;

   typedef struct packed {
      phase_type               phase;
      logic [3:0]              bit_count;
      logic [7:0]              shift_byte;
      logic [DELAY_BITS-1:0]   wait_count;
      logic [TIMEOUT_BITS-1:0] stretch_count;
      logic                    stretching;
      logic                    scl_drive;
      logic                    sda_drive;
      logic                    send_ack;
      logic                    skip_ack;
      logic                    lsb_first;
      logic [1:0]              last_status;
      logic [7:0]              rx_hold;
   } seq_type;

   // one tick of input: command fields plus sampled pins
   typedef struct packed {
      logic [2:0] func;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       skip_ack;
      logic       lsb_first;
      logic       scl_in;
      logic       sda_in;
   } tick_type;

   localparam cfg_type CFG_RESET = '{
      delay:   DELAY_BITS'(10),
      timeout: TIMEOUT_BITS'(1000),
      sense:   1'b1
   };

   localparam seq_type SEQ_RESET = '{
      phase:         PH_IDLE,
      bit_count:     4'd0,
      shift_byte:    8'd0,
      wait_count:    '0,
      stretch_count: '0,
      stretching:    1'b0,
      scl_drive:     1'b1,
      sda_drive:     1'b1,
      send_ack:      1'b0,
      skip_ack:      1'b0,
      lsb_first:     1'b0,
      last_status:   STATUS_OK,
      rx_hold:       8'd0
   };

   // bit reversal of a byte
   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[i];
      end
      return r;
   endfunction

endpackage

[rtl/core/i2c_master_byte_engine_unit.sv]
// I2C master byte engine: one transfer per clock tick on req_, one result per tick on rsp_.
// Latency: the result of a transfer is registered and shown the cycle after it is taken.
// Throughput: one transfer per cycle while req_ready is high; the state step is a single registered pass.
// req_ready stays high while the result register is empty or being drained.
// Reset (synchronous, active high): sequencer idle, pins released, registers to defaults.
// Depends on i2cmbe_pkg, i2cmbe_step and i2c_master_byte_engine_unit_assert.svh.
`include "i2c_master_byte_engine_unit_assert.svh"

module i2c_master_byte_engine_unit (
   input  logic        clock,
   input  logic        reset,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   // tick input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_send_ack,
   input  logic        req_skip_ack,
   input  logic        req_lsb_first,
   input  logic        req_scl_in,
   input  logic        req_sda_in,
   // tick result
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_rx_byte,
   output logic [1:0]  rsp_status
);
   import i2cmbe_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   seq_type    state_ff, state_in, step_nxt;
   tick_type   tick;
   logic       step_done;
   logic       req_accept;
   logic       cfg_write;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff;
   logic [7:0] rsp_rx_ff;
   logic [1:0] rsp_status_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (csr_paddr[3:2])
            REG_DELAY:   cfg_in.delay   = csr_pwdata[DELAY_BITS-1:0];
            REG_TIMEOUT: cfg_in.timeout = csr_pwdata[TIMEOUT_BITS-1:0];
            REG_SENSE:   cfg_in.sense   = csr_pwdata[0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DELAY:   csr_prdata = 32'(cfg_ff.delay);
         REG_TIMEOUT: csr_prdata = 32'(cfg_ff.timeout);
         REG_SENSE:   csr_prdata = 32'(cfg_ff.sense);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer step
   assign tick = '{func: req_func, tx_byte: req_tx_byte, send_ack: req_send_ack,
                   skip_ack: req_skip_ack, lsb_first: req_lsb_first,
                   scl_in: req_scl_in, sda_in: req_sda_in};

   i2cmbe_step u_step (
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .tick (tick),
      .nxt  (step_nxt),
      .done (step_done)
   );

   assign req_ready  = ~rsp_valid_ff | rsp_ready;
   assign req_accept = req_valid & req_ready;
   assign state_in   = req_accept ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   // result register
   assign rsp_valid_in = req_accept | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_scl_ff    <= step_nxt.scl_drive;
         rsp_sda_ff    <= step_nxt.sda_drive;
         rsp_busy_ff   <= (step_nxt.phase != PH_IDLE);
         rsp_done_ff   <= step_done;
         rsp_rx_ff     <= step_nxt.rx_hold;
         rsp_status_ff <= step_nxt.last_status;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_scl_out  = rsp_scl_ff;
   assign rsp_sda_out  = rsp_sda_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_done_res = rsp_done_ff;
   assign rsp_rx_byte  = rsp_rx_ff;
   assign rsp_status   = rsp_status_ff;

   // checks
   `I2CMBE_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff.phase == PH_IDLE) && !rsp_valid_ff, "sequencer not idle after reset")
   `I2CMBE_ASSERT(a_busy_matches, rsp_valid_ff |-> (rsp_busy_ff == (state_ff.phase != PH_IDLE)), "busy result disagrees with sequencer phase")
   `I2CMBE_ASSERT(a_done_idle, (rsp_valid_ff && rsp_done_ff) |-> (state_ff.phase == PH_IDLE), "done shown while sequencer still active")
   `I2CMBE_ASSERT(a_stretch_released, state_ff.stretching |-> state_ff.scl_drive, "waiting on clock stretch with SCL pulled low")
   `I2CMBE_ASSERT(a_hold_state, !req_accept |=> $stable(state_ff.phase) && $stable(state_ff.wait_count), "sequencer moved without a transfer")

endmodule

[rtl/core/i2cmbe_step.sv]
// Next-state logic of the I2C master byte engine: one sequencer tick.
// Depends on i2cmbe_pkg; instantiated by i2c_master_byte_engine_unit.
module i2cmbe_step (
   input  i2cmbe_pkg::seq_type  cur,
   input  i2cmbe_pkg::cfg_type  cfg,
   input  i2cmbe_pkg::tick_type tick,
   output i2cmbe_pkg::seq_type  nxt,
   output logic                 done
);
   import i2cmbe_pkg::*;

   logic [DELAY_BITS-1:0] half;
   seq_type               launch;
   phase_type             follow;

   // rounded half delay, (delay+1)/2
   assign half = DELAY_BITS'(({1'b0, cfg.delay} + (DELAY_BITS+1)'(1)) >> 1);

   // pin action taken on entering a phase
   function automatic seq_type enter_phase(input phase_type p, input seq_type s_in,
                                           input logic sda, input cfg_type c,
                                           input logic [DELAY_BITS-1:0] hd);
      seq_type    s;
      logic [7:0] sh;
      logic [3:0] cnt;
      s     = s_in;
      sh    = {s_in.shift_byte[6:0], sda};
      cnt   = s_in.bit_count + 4'd1;
      s.phase = p;
      unique case (p) inside
         PH_START_SDA: begin
            s.sda_drive = 1'b0; s.wait_count = c.delay;
         end
         PH_START_SCL: begin
            s.scl_drive = 1'b0; s.wait_count = hd;
         end
         PH_RS_SDA, PH_RD_REL, PH_WR_REL: begin
            s.sda_drive = 1'b1; s.wait_count = hd;
         end
         PH_SP_SDA: begin
            s.sda_drive = 1'b0; s.wait_count = hd;
         end
         PH_SP_REL: begin
            s.sda_drive = 1'b1; s.wait_count = c.delay;
         end
         PH_WR_BIT: begin
            s.sda_drive  = |(s_in.shift_byte & BYTE_MSB);
            s.shift_byte = {s_in.shift_byte[6:0], 1'b0};
            s.wait_count = hd;
         end
         PH_WR_SCLLO: begin
            s.scl_drive = 1'b0; s.bit_count = cnt; s.wait_count = hd;
         end
         PH_WR_ACKLO: begin
            if (sda) begin
               s.last_status = STATUS_NAK;
            end
            s.scl_drive = 1'b0; s.wait_count = hd;
         end
         PH_RD_SAMPLE: begin
            s.shift_byte = sh;
            s.scl_drive  = 1'b0;
            s.bit_count  = cnt;
            if (cnt >= BITS_BYTE) begin
               s.rx_hold    = s_in.lsb_first ? rev8(sh) : sh;
               s.wait_count = hd;
            end else begin
               s.wait_count = c.delay;
            end
         end
         PH_AK_SDA: begin
            if (s_in.send_ack) begin
               s.sda_drive = 1'b0;
            end
            s.wait_count = hd;
         end
         PH_AK_SCLLO: begin
            s.scl_drive = 1'b0; s.wait_count = hd;
         end
         PH_RS_SCLHI, PH_SP_SCLHI, PH_WR_SCLHI, PH_WR_ACKHI, PH_RD_SCLHI,
         PH_AK_SCLHI: begin
            // release SCL; wait for it to read high when sensing
            s.scl_drive = 1'b1;
            if (c.sense) begin
               s.stretching    = 1'b1;
               s.stretch_count = '0;
            end else begin
               s.wait_count = c.delay;
            end
         end
         default: s.phase = PH_IDLE;
      endcase
      return s;
   endfunction

   // phase after the current wait; idle marks the end of a command
   always_comb begin
      unique case (cur.phase)
         PH_START_SDA: follow = PH_START_SCL;
         PH_RS_SDA:    follow = PH_RS_SCLHI;
         PH_RS_SCLHI:  follow = PH_START_SDA;
         PH_SP_SDA:    follow = PH_SP_SCLHI;
         PH_SP_SCLHI:  follow = PH_SP_REL;
         PH_WR_BIT:    follow = PH_WR_SCLHI;
         PH_WR_SCLHI:  follow = PH_WR_SCLLO;
         PH_WR_SCLLO:  follow = (cur.bit_count < BITS_BYTE) ? PH_WR_BIT : PH_WR_REL;
         PH_WR_REL:    follow = PH_WR_ACKHI;
         PH_WR_ACKHI:  follow = PH_WR_ACKLO;
         PH_RD_REL:    follow = PH_RD_SCLHI;
         PH_RD_SCLHI:  follow = PH_RD_SAMPLE;
         PH_RD_SAMPLE: begin
            if (cur.bit_count < BITS_BYTE) begin
               follow = PH_RD_SCLHI;
            end else begin
               follow = cur.skip_ack ? PH_IDLE : PH_AK_SDA;
            end
         end
         PH_AK_SDA:    follow = PH_AK_SCLHI;
         PH_AK_SCLHI:  follow = PH_AK_SCLLO;
         default:      follow = PH_IDLE;
      endcase
   end

   // command setup on an idle tick
   always_comb begin
      launch             = cur;
      launch.send_ack    = tick.send_ack;
      launch.skip_ack    = tick.skip_ack;
      launch.lsb_first   = tick.lsb_first;
      launch.last_status = STATUS_OK;
      launch.bit_count   = 4'd0;
      launch.stretching  = 1'b0;
      launch.shift_byte  = tick.lsb_first ? rev8(tick.tx_byte) : tick.tx_byte;
   end

   // one tick of the sequencer
   always_comb begin
      nxt  = cur;
      done = 1'b0;
      if (cur.phase == PH_IDLE) begin
         unique case (tick.func)
            FUNC_START:   nxt = enter_phase(PH_START_SDA, launch, tick.sda_in, cfg, half);
            FUNC_RESTART: nxt = enter_phase(PH_RS_SDA, launch, tick.sda_in, cfg, half);
            FUNC_STOP:    nxt = enter_phase(PH_SP_SDA, launch, tick.sda_in, cfg, half);
            FUNC_WRITE:   nxt = enter_phase(PH_WR_BIT, launch, tick.sda_in, cfg, half);
            FUNC_READ: begin
               nxt            = launch;
               nxt.shift_byte = 8'd0;
               nxt            = enter_phase(PH_RD_REL, nxt, tick.sda_in, cfg, half);
            end
            default:      nxt = cur;
         endcase
      end else if (cur.stretching) begin
         if (tick.scl_in) begin
            nxt.stretching = 1'b0;
            nxt.wait_count = cfg.delay;
         end else if (cur.stretch_count >= cfg.timeout) begin
            nxt.stretching  = 1'b0;
            nxt.last_status = STATUS_TIMEOUT;
            nxt.phase       = PH_IDLE;
            done            = 1'b1;
         end else begin
            nxt.stretch_count = cur.stretch_count + TIMEOUT_BITS'(1);
         end
      end else if (cur.wait_count > DELAY_BITS'(1)) begin
         nxt.wait_count = cur.wait_count - DELAY_BITS'(1);
      end else begin
         nxt.wait_count = '0;
         if (follow == PH_IDLE) begin
            nxt.phase = PH_IDLE;
            done      = 1'b1;
         end else begin
            nxt = enter_phase(follow, nxt, tick.sda_in, cfg, half);
         end
      end
   end

endmodule

[tb/tb_i2c_master_byte_engine_unit.sv]
// Self-checking testbench for the I2C master byte engine: per-tick line state prediction.
// Drives tick transfers with random pins and stalls, compares every result transfer.
// Depends on i2cmbe_pkg and the i2c_master_byte_engine_unit RTL.
module tb_i2c_master_byte_engine_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cmbe_pkg::*;

   // func values the engine treats as no command
   localparam logic [2:0]  FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0]  FUNC_SPARE_HI = 3'd7;
   localparam logic [31:0] TMO_MAX       = (32'd1 << TIMEOUT_BITS) - 32'd1;
   localparam int          QUIET_LIMIT   = 4000;
   localparam int          REPORT_CAP    = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = FUNC_NONE;
   logic [7:0]  req_tx_byte = '0;
   logic        req_send_ack = 1'b0;
   logic        req_skip_ack = 1'b0;
   logic        req_lsb_first = 1'b0;
   logic        req_scl_in = 1'b1;
   logic        req_sda_in = 1'b1;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_scl_out;
   logic        rsp_sda_out;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_rx_byte;
   logic [1:0]  rsp_status;

   // stimulus knobs in percent, plus the quiet counter of the watchdog
   int idle_pct   = 27;
   int low_pct    = 0;
   int sda_hi_pct = 50;
   int noise_pct  = 0;
   int quiet      = 0;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rx;
      logic [1:0] st;
   } bus_line_type;

   // Tracks the sequencer tick by tick and holds the line states still owed by the DUT
   class bus_line_tracker_type;
      logic [DELAY_BITS-1:0]   dly;
      logic [TIMEOUT_BITS-1:0] tmo;
      logic                    sense;
      phase_type               ph;
      logic [3:0]              nbits;
      logic [7:0]              shreg;
      logic [DELAY_BITS-1:0]   wait_left;
      logic [TIMEOUT_BITS-1:0] stretch_cnt;
      logic                    stretching;
      logic                    scl_d;
      logic                    sda_d;
      logic                    f_ack;
      logic                    f_skip;
      logic                    f_lsb;
      logic [1:0]              stat;
      logic [7:0]              rx_last;
      bus_line_type            pending_lines[$];
      int                      errors;
      int                      ticks;
      int                      cmd_count[8];
      int                      unknown_codes;
      int                      dones;
      int                      naks;
      int                      timeouts;

      function new();
         dly = DELAY_BITS'(10);
         tmo = TIMEOUT_BITS'(1000);
         sense = 1'b1;
         ph = PH_IDLE;
         nbits = '0;
         shreg = '0;
         wait_left = '0;
         stretch_cnt = '0;
         stretching = 1'b0;
         scl_d = 1'b1;
         sda_d = 1'b1;
         f_ack = 1'b0;
         f_skip = 1'b0;
         f_lsb = 1'b0;
         stat = STATUS_OK;
         rx_last = '0;
         errors = 0;
         ticks = 0;
         unknown_codes = 0;
         dones = 0;
         naks = 0;
         timeouts = 0;
         foreach (cmd_count[i]) cmd_count[i] = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] v);
         case (idx)
            REG_DELAY:   dly = v[DELAY_BITS-1:0];
            REG_TIMEOUT: tmo = v[TIMEOUT_BITS-1:0];
            REG_SENSE:   sense = v[0];
            default: ;
         endcase
      endfunction

      function logic [7:0] flip(logic [7:0] v);
         return {<<{v}};
      endfunction

      // rounded half of the bit delay
      function logic [DELAY_BITS-1:0] half_wait();
         logic [DELAY_BITS:0] s;
         s = {1'b0, dly} + 1'b1;
         return s[DELAY_BITS:1];
      endfunction

      // pin action taken on entering a phase
      function void take_action(phase_type p, logic sda);
         ph = p;
         case (p) inside
            PH_START_SDA: begin
               sda_d = 1'b0;
               wait_left = dly;
            end
            PH_START_SCL: begin
               scl_d = 1'b0;
               wait_left = half_wait();
            end
            PH_RS_SDA, PH_RD_REL, PH_WR_REL: begin
               sda_d = 1'b1;
               wait_left = half_wait();
            end
            PH_SP_SDA: begin
               sda_d = 1'b0;
               wait_left = half_wait();
            end
            PH_SP_REL: begin
               sda_d = 1'b1;
               wait_left = dly;
            end
            PH_WR_BIT: begin
               sda_d = ((shreg & BYTE_MSB) != 0);
               shreg = shreg << 1;
               wait_left = half_wait();
            end
            PH_WR_SCLLO: begin
               scl_d = 1'b0;
               nbits++;
               wait_left = half_wait();
            end
            PH_WR_ACKLO: begin
               if (sda) stat = STATUS_NAK;
               scl_d = 1'b0;
               wait_left = half_wait();
            end
            PH_RD_SAMPLE: begin
               shreg = {shreg[6:0], sda};
               scl_d = 1'b0;
               nbits++;
               if (nbits >= BITS_BYTE) begin
                  rx_last = f_lsb ? flip(shreg) : shreg;
                  wait_left = half_wait();
               end else begin
                  wait_left = dly;
               end
            end
            PH_AK_SDA: begin
               if (f_ack) sda_d = 1'b0;
               wait_left = half_wait();
            end
            PH_AK_SCLLO: begin
               scl_d = 1'b0;
               wait_left = half_wait();
            end
            // SCL release: either wait for the line or start the full delay now
            PH_RS_SCLHI, PH_SP_SCLHI, PH_WR_SCLHI, PH_WR_ACKHI, PH_RD_SCLHI,
            PH_AK_SCLHI: begin
               scl_d = 1'b1;
               if (sense) begin
                  stretching = 1'b1;
                  stretch_cnt = '0;
               end else begin
                  wait_left = dly;
               end
            end
            default: ph = PH_IDLE;
         endcase
      endfunction

      // successor phase; ends is set when the command is complete
      function phase_type next_step(phase_type p, output bit ends);
         phase_type n;
         ends = 1'b0;
         n = PH_IDLE;
         case (p)
            PH_START_SDA: n = PH_START_SCL;
            PH_RS_SDA:    n = PH_RS_SCLHI;
            PH_RS_SCLHI:  n = PH_START_SDA;
            PH_SP_SDA:    n = PH_SP_SCLHI;
            PH_SP_SCLHI:  n = PH_SP_REL;
            PH_WR_BIT:    n = PH_WR_SCLHI;
            PH_WR_SCLHI:  n = PH_WR_SCLLO;
            PH_WR_SCLLO:  n = (nbits < BITS_BYTE) ? PH_WR_BIT : PH_WR_REL;
            PH_WR_REL:    n = PH_WR_ACKHI;
            PH_WR_ACKHI:  n = PH_WR_ACKLO;
            PH_RD_REL:    n = PH_RD_SCLHI;
            PH_RD_SCLHI:  n = PH_RD_SAMPLE;
            PH_RD_SAMPLE: begin
               if (nbits < BITS_BYTE) n = PH_RD_SCLHI;
               else if (f_skip) ends = 1'b1;
               else n = PH_AK_SDA;
            end
            PH_AK_SDA:    n = PH_AK_SCLHI;
            PH_AK_SCLHI:  n = PH_AK_SCLLO;
            default:      ends = 1'b1;
         endcase
         return n;
      endfunction

      // one accepted tick: advance the sequencer and queue the line state it yields
      function void note_tick(tick_type t);
         bus_line_type want;
         phase_type    n;
         bit           ends;
         logic         done_now;
         done_now = 1'b0;
         ticks++;
         if (ph == PH_IDLE) begin
            if (t.func >= FUNC_START && t.func <= FUNC_READ) begin
               cmd_count[t.func]++;
               f_ack = t.send_ack;
               f_skip = t.skip_ack;
               f_lsb = t.lsb_first;
               stat = STATUS_OK;
               nbits = '0;
               stretching = 1'b0;
               shreg = t.lsb_first ? flip(t.tx_byte) : t.tx_byte;
               case (t.func)
                  FUNC_START:   take_action(PH_START_SDA, t.sda_in);
                  FUNC_RESTART: take_action(PH_RS_SDA, t.sda_in);
                  FUNC_STOP:    take_action(PH_SP_SDA, t.sda_in);
                  FUNC_WRITE:   take_action(PH_WR_BIT, t.sda_in);
                  default: begin
                     shreg = '0;
                     take_action(PH_RD_REL, t.sda_in);
                  end
               endcase
            end else if (t.func == FUNC_SPARE_LO || t.func == FUNC_SPARE_HI) begin
               unknown_codes++;
            end
         end else if (stretching) begin
            // slave holds SCL low: count samples until release or timeout
            if (t.scl_in) begin
               stretching = 1'b0;
               wait_left = dly;
            end else if (stretch_cnt >= tmo) begin
               stretching = 1'b0;
               stat = STATUS_TIMEOUT;
               ph = PH_IDLE;
               done_now = 1'b1;
            end else begin
               stretch_cnt++;
            end
         end else if (wait_left > 1) begin
            wait_left--;
         end else begin
            n = next_step(ph, ends);
            wait_left = '0;
            if (ends) begin
               ph = PH_IDLE;
               done_now = 1'b1;
            end else begin
               take_action(n, t.sda_in);
            end
         end
         if (done_now) begin
            dones++;
            if (stat == STATUS_NAK) naks++;
            if (stat == STATUS_TIMEOUT) timeouts++;
         end
         want.scl = scl_d;
         want.sda = sda_d;
         want.busy = (ph != PH_IDLE);
         want.done = done_now;
         want.rx = rx_last;
         want.st = stat;
         pending_lines.push_back(want);
      endfunction

      function void compare(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_CAP)
               $error("%s expected %0h got %0h", field, want, got);
         end
      endfunction

      function void check_line(bus_line_type got);
         bus_line_type want;
         if (pending_lines.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP) $error("result transfer with no line state owed");
            return;
         end
         want = pending_lines.pop_front();
         compare("scl_out", 8'(want.scl), 8'(got.scl));
         compare("sda_out", 8'(want.sda), 8'(got.sda));
         compare("busy_res", 8'(want.busy), 8'(got.busy));
         compare("done_res", 8'(want.done), 8'(got.done));
         compare("rx_byte", want.rx, got.rx);
         compare("status", 8'(want.st), 8'(got.st));
      endfunction

      function void wrap_up();
         if (pending_lines.size() != 0) begin
            errors++;
            $error("%0d line states never delivered", pending_lines.size());
         end
      endfunction
   endclass

   bus_line_tracker_type book = new();

   i2c_master_byte_engine_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_tx_byte   (req_tx_byte),
      .req_send_ack  (req_send_ack),
      .req_skip_ack  (req_skip_ack),
      .req_lsb_first (req_lsb_first),
      .req_scl_in    (req_scl_in),
      .req_sda_in    (req_sda_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_scl_out   (rsp_scl_out),
      .rsp_sda_out   (rsp_sda_out),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_rx_byte   (rsp_rx_byte),
      .rsp_status    (rsp_status)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   // result transfer checker
   always @(posedge clock) begin
      bus_line_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.scl = rsp_scl_out;
         got.sda = rsp_sda_out;
         got.busy = rsp_busy_res;
         got.done = rsp_done_res;
         got.rx = rsp_rx_byte;
         got.st = rsp_status;
         book.check_line(got);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // tick with random pins; noise commands only while a command runs
   function automatic tick_type filler_tick();
      tick_type t;
      t.func = FUNC_NONE;
      if (book.ph != PH_IDLE && $urandom_range(99) < noise_pct)
         t.func = 3'($urandom_range(7));
      t.tx_byte = 8'($urandom);
      t.send_ack = 1'($urandom);
      t.skip_ack = 1'($urandom);
      t.lsb_first = 1'($urandom);
      t.scl_in = ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1;
      t.sda_in = ($urandom_range(99) < sda_hi_pct) ? 1'b1 : 1'b0;
      return t;
   endfunction

   // present one tick and hold it until the transfer
   task automatic push_tick(tick_type t);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= t.func;
      req_tx_byte <= t.tx_byte;
      req_send_ack <= t.send_ack;
      req_skip_ack <= t.skip_ack;
      req_lsb_first <= t.lsb_first;
      req_scl_in <= t.scl_in;
      req_sda_in <= t.sda_in;
      do @(posedge clock); while (!req_ready);
      book.note_tick(t);
   endtask

   // issue a command from idle and clock it until the sequencer is idle again
   task automatic run_cmd(logic [2:0] f, logic [7:0] b, logic ack, logic skip, logic lsb);
      tick_type t;
      t = filler_tick();
      t.func = f;
      t.tx_byte = b;
      t.send_ack = ack;
      t.skip_ack = skip;
      t.lsb_first = lsb;
      push_tick(t);
      while (book.ph != PH_IDLE) push_tick(filler_tick());
   endtask

   // random commands until roughly the given number of ticks has been sent
   task automatic random_cmds(int budget);
      int         pick;
      int         stop_at;
      logic [2:0] f;
      stop_at = book.ticks + budget;
      while (book.ticks < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 15) f = FUNC_START;
         else if (pick < 25) f = FUNC_RESTART;
         else if (pick < 40) f = FUNC_STOP;
         else if (pick < 68) f = FUNC_WRITE;
         else if (pick < 95) f = FUNC_READ;
         else if (pick < 97) f = FUNC_SPARE_LO;
         else if (pick < 99) f = FUNC_SPARE_HI;
         else f = FUNC_NONE;
         run_cmd(f, 8'($urandom), 1'($urandom), ($urandom_range(3) == 0), 1'($urandom));
         repeat ($urandom_range(2)) push_tick(filler_tick());
      end
   endtask

   // stop ticking and wait for every owed line state
   task automatic drain_lines();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.pending_lines.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      book.set_reg(idx, val);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_bus(logic [31:0] dly, logic [31:0] tmo, logic [31:0] sense);
      drain_lines();
      csr_write(REG_DELAY, dly);
      csr_write(REG_TIMEOUT, tmo);
      csr_write(REG_SENSE, sense);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short commands at reset defaults
      run_cmd(FUNC_START, 8'h00, 1'b0, 1'b0, 1'b0);
      run_cmd(FUNC_SPARE_LO, 8'h11, 1'b1, 1'b1, 1'b1);
      run_cmd(FUNC_SPARE_HI, 8'h22, 1'b0, 1'b0, 1'b0);
      run_cmd(FUNC_NONE, 8'h33, 1'b0, 1'b0, 1'b0);
      run_cmd(FUNC_STOP, 8'h00, 1'b0, 1'b0, 1'b0);

      // delay 1, tight timeout: directed byte commands
      set_bus(32'd1, 32'd3, 32'd1);
      sda_hi_pct = 0;
      run_cmd(FUNC_WRITE, 8'hA5, 1'b0, 1'b0, 1'b0);
      sda_hi_pct = 100;
      run_cmd(FUNC_WRITE, 8'h3C, 1'b0, 1'b0, 1'b1);
      run_cmd(FUNC_READ, 8'h00, 1'b1, 1'b0, 1'b0);
      sda_hi_pct = 0;
      run_cmd(FUNC_READ, 8'hFF, 1'b0, 1'b0, 1'b0);
      sda_hi_pct = 50;
      run_cmd(FUNC_READ, 8'h5A, 1'b1, 1'b1, 1'b1);
      run_cmd(FUNC_RESTART, 8'h00, 1'b0, 1'b0, 1'b0);
      // commands arriving while busy must be ignored
      noise_pct = 100;
      run_cmd(FUNC_WRITE, 8'h81, 1'b0, 1'b0, 1'b0);
      noise_pct = 0;
      // honored stretching, then a stretch that outlasts the timeout
      low_pct = 60;
      run_cmd(FUNC_WRITE, 8'h6E, 1'b0, 1'b0, 1'b0);
      low_pct = 100;
      run_cmd(FUNC_READ, 8'h00, 1'b1, 1'b0, 1'b0);
      low_pct = 30;
      noise_pct = 15;
      random_cmds(60);

      // zero delay and zero timeout
      set_bus(32'd0, 32'd0, 32'd1);
      low_pct = 0;
      run_cmd(FUNC_START, 8'h00, 1'b0, 1'b0, 1'b0);
      low_pct = 100;
      run_cmd(FUNC_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
      low_pct = 10;
      random_cmds(40);

      // sensing off: SCL level never matters
      set_bus(32'd2, 32'd20, 32'd0);
      low_pct = 50;
      random_cmds(60);

      // largest timeout
      set_bus(32'd5, TMO_MAX, 32'd1);
      low_pct = 40;
      random_cmds(40);

      // back-to-back transfers with no stalls
      idle_pct = 0;
      set_bus(32'd3, 32'd7, 32'd1);
      low_pct = 30;
      random_cmds(100);
      idle_pct = 27;

      drain_lines();
      repeat (8) @(posedge clock);
      book.wrap_up();

      $display("Ran %0d ticks: %0d start, %0d restart, %0d stop, %0d write, %0d read, %0d unknown",
               book.ticks, book.cmd_count[FUNC_START], book.cmd_count[FUNC_RESTART],
               book.cmd_count[FUNC_STOP], book.cmd_count[FUNC_WRITE],
               book.cmd_count[FUNC_READ], book.unknown_codes);
      $display("%0d commands completed, %0d with NAK, %0d timed out; %0d mismatches",
               book.dones, book.naks, book.timeouts, book.errors);
      if (book.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
